@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/msb_pkg.sv @@
// ----------------------------------------------------------------------------
// msb_pkg
// Shared codes and controller/datapath interface types for the blitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msb_pkg;

  // command opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FB_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FB_HEIGHT = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat, clear counters
    logic mul;       // register row base / pixel total product
    logic clr_step;  // write one clear pixel
    logic drw_step;  // test and write one sprite column
    logic rd;        // read one pixel
    logic res_load;  // load result register
  } msb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       total_zero;  // buffer has no pixels in use
    logic       draw_go;     // row inside sprite and buffer, nonzero width
    logic       read_go;     // read pixel inside buffer
    logic       clr_last;    // current clear pixel is the last one
    logic       drw_last;    // current sprite column is the last one
    logic       out_busy;    // result register full and stalled
  } msb_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/msb_ctrl.sv @@
// ----------------------------------------------------------------------------
// msb_ctrl
// Command sequencer: accepts one command, steps the datapath, posts result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msb_ctrl
  import msb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire msb_stat_t stat,
  output msb_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_CLEAR,
    S_DRAW,
    S_READ,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.mul = 1'b1;
        case (stat.op)
          OP_CLEAR: state_next = stat.total_zero ? S_DONE : S_CLEAR;
          OP_DRAW:  state_next = stat.draw_go ? S_DRAW : S_DONE;
          OP_READ:  state_next = stat.read_go ? S_READ : S_DONE;
          default:  state_next = S_DONE;
        endcase
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_DONE;
        end
      end
      S_DRAW: begin
        cmd.drw_step = 1'b1;
        if (stat.drw_last) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/msb_datapath.sv @@
// ----------------------------------------------------------------------------
// msb_datapath
// Config registers, clipping, address multiplier, frame memory and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msb_datapath
  import msb_pkg::*;
#(
  parameter int FB_MAX_WIDTH      = 256,
  parameter int FB_MAX_HEIGHT     = 256,
  parameter int SPRITE_MAX_WIDTH  = 16,
  parameter int SPRITE_MAX_HEIGHT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic [1:0]  opcode,
  input  wire logic [9:0]  pos_x,
  input  wire logic [9:0]  pos_y,
  input  wire logic [3:0]  row_index,
  input  wire logic [4:0]  sprite_width,
  input  wire logic [4:0]  sprite_height,
  input  wire logic [15:0] row_mask,
  input  wire logic [31:0] color,
  input  wire msb_cmd_t    cmd,
  output msb_stat_t        stat,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [31:0]      pixel_value,
  output logic [16:0]      pixels_written
);

  localparam int DEPTH  = FB_MAX_WIDTH * FB_MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int PROD_W = 18;

  // clamp limits; a 9-bit register can never exceed a limit of 511 or more
  localparam logic [8:0] W_CAP  = (FB_MAX_WIDTH < 511) ? 9'(FB_MAX_WIDTH) : 9'd511;
  localparam logic [8:0] H_CAP  = (FB_MAX_HEIGHT < 511) ? 9'(FB_MAX_HEIGHT) : 9'd511;
  localparam int         SW_LIM = (SPRITE_MAX_WIDTH < 16) ? SPRITE_MAX_WIDTH : 16;
  localparam int         SH_LIM = (SPRITE_MAX_HEIGHT < 31) ? SPRITE_MAX_HEIGHT : 31;
  localparam logic [4:0] SW_CAP = 5'(SW_LIM);
  localparam logic [4:0] SH_CAP = 5'(SH_LIM);

  logic [8:0]        fb_width;
  logic [8:0]        fb_height;
  logic [1:0]        op;
  logic [9:0]        px;
  logic [9:0]        py;
  logic [3:0]        row;
  logic [4:0]        sw;
  logic [4:0]        sh;
  logic [15:0]       mask;
  logic [31:0]       wcolor;
  logic [PROD_W-1:0] base;
  logic [CNT_W-1:0]  idx;
  logic [3:0]        col;
  logic [4:0]        cnt;
  logic [31:0]       rd_data;
  logic [31:0]       mem [DEPTH];

  logic [8:0]        w;
  logic [8:0]        h;
  logic [4:0]        ew;
  logic [4:0]        eh;
  logic [10:0]       sy;
  logic [10:0]       sx;
  logic              sx_in;
  logic              col_wr;
  logic [8:0]        mul_a;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_width  <= 9'd224;
      fb_height <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FB_WIDTH:  fb_width  <= cfg_data;
        CFG_FB_HEIGHT: fb_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes and clipping tests
  assign w      = (fb_width > W_CAP) ? W_CAP : fb_width;
  assign h      = (fb_height > H_CAP) ? H_CAP : fb_height;
  assign ew     = (sw > SW_CAP) ? SW_CAP : sw;
  assign eh     = (sh > SH_CAP) ? SH_CAP : sh;
  assign sy     = 11'(py) + 11'(eh) - 11'd1 - 11'(row);
  assign sx     = 11'(px) + 11'(col);
  assign sx_in  = (sx < 11'(w));
  assign col_wr = mask[col] && sx_in;

  assign stat.op         = op;
  assign stat.total_zero = (w == 9'd0) || (h == 9'd0);
  assign stat.draw_go    = ({1'b0, row} < eh) && (sy < 11'(h)) && (ew != 5'd0);
  assign stat.read_go    = (10'(w) > px) && (10'(h) > py);
  assign stat.clr_last   = ((idx + CNT_W'(1)) == CNT_W'(base));
  assign stat.drw_last   = ({1'b0, col} == (ew - 5'd1));
  assign stat.out_busy   = out_valid && out_stall;

  // multiplier operand: pixel total for clear, row base otherwise
  always_comb begin
    case (op)
      OP_CLEAR: mul_a = h;
      OP_DRAW:  mul_a = sy[8:0];
      default:  mul_a = py[8:0];
    endcase
  end

  // command capture, product and step counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= opcode;
      px     <= pos_x;
      py     <= pos_y;
      row    <= row_index;
      sw     <= sprite_width;
      sh     <= sprite_height;
      mask   <= row_mask;
      wcolor <= color;
      idx    <= '0;
      col    <= '0;
      cnt    <= '0;
    end
    if (cmd.mul) begin
      base <= mul_a * w;
    end
    if (cmd.clr_step) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.drw_step) begin
      col <= col + 4'd1;
      if (col_wr) begin
        cnt <= cnt + 5'd1;
      end
    end
  end

  // single memory port address
  always_comb begin
    if (cmd.clr_step) begin
      mem_addr = idx[ADDR_W-1:0];
    end else if (cmd.drw_step) begin
      mem_addr = ADDR_W'(base + PROD_W'(sx));
    end else begin
      mem_addr = ADDR_W'(base + PROD_W'(px));
    end
  end

  assign mem_we = cmd.clr_step || (cmd.drw_step && col_wr);

  // frame memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wcolor;
    end
    if (cmd.rd) begin
      rd_data <= mem[mem_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      pixel_value <= ((op == OP_READ) && stat.read_go) ? rd_data : 32'd0;
      case (op)
        OP_CLEAR: pixels_written <= base[16:0];
        OP_DRAW:  pixels_written <= 17'(cnt);
        default:  pixels_written <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/masked_sprite_blitter_core.sv @@
// ----------------------------------------------------------------------------
// masked_sprite_blitter_core
// Framebuffer command engine: clear, one-bit sprite row draw, pixel read.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | beat
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall   | opcode, pos, sprite, mask, color
//  out     | out       | out_valid/out_stall | pixel_value, pixels_written
//
//  A command is captured, set up, stepped a pixel or sprite column at a time
//  (single-port memory) or read once, and posted; clipped/empty ones skip ahead.
//  The next command is taken once the previous result sits in the output
//  register; a stalled output holds that result and the engine waits to post.
//  Reset (rst, synchronous) restores 224x256 and leaves pixel data undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module masked_sprite_blitter_core
  import msb_pkg::*;
#(
  parameter int FB_MAX_WIDTH      = 256,
  parameter int FB_MAX_HEIGHT     = 256,
  parameter int SPRITE_MAX_WIDTH  = 16,
  parameter int SPRITE_MAX_HEIGHT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [9:0]  pos_x,
  input  wire logic [9:0]  pos_y,
  input  wire logic [3:0]  row_index,
  input  wire logic [4:0]  sprite_width,
  input  wire logic [4:0]  sprite_height,
  input  wire logic [15:0] row_mask,
  input  wire logic [31:0] color,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      pixel_value,
  output logic [16:0]      pixels_written
);

  msb_cmd_t   cmd;
  msb_stat_t  stat;
  logic [2:0] mem_ops;

  assign cfg_ready = 1'b1;
  assign mem_ops   = {cmd.clr_step, cmd.drw_step, cmd.rd};

  msb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  msb_datapath #(
    .FB_MAX_WIDTH      (FB_MAX_WIDTH),
    .FB_MAX_HEIGHT     (FB_MAX_HEIGHT),
    .SPRITE_MAX_WIDTH  (SPRITE_MAX_WIDTH),
    .SPRITE_MAX_HEIGHT (SPRITE_MAX_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .row_index      (row_index),
    .sprite_width   (sprite_width),
    .sprite_height  (sprite_height),
    .row_mask       (row_mask),
    .color          (color),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .pixel_value    (pixel_value),
    .pixels_written (pixels_written)
  );

  // an accepted command keeps the input side closed while it runs
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "missing stall")
  // a result is never posted over one still waiting
  `ASSERT_ALWAYS(a_no_overwrite, clk, rst, !(cmd.res_load && stat.out_busy), "result lost")
  // a posted result shows up on the output
  `ASSERT_NEXT(a_post_valid, clk, rst, cmd.res_load, out_valid, "posted result not valid")
  // the memory port serves one operation at a time
  `ASSERT_ALWAYS(a_one_mem_op, clk, rst, $onehot0(mem_ops), "memory port conflict")

endmodule

`default_nettype wire
